// ----- sv/lsfp_pkg.sv -----
// ----------------------------------------------------------------------------
// lsfp_pkg
// Shared types and constants for the level sensor frame parser: frame
// layout, divider size and the command/status bundles between controller
// and datapath.
// ----------------------------------------------------------------------------
package lsfp_pkg;

  // frame layout
  localparam logic [7:0] SYNC_BYTE     = 8'hFF;
  localparam int         FRAME_LEN     = 4;
  localparam logic [1:0] POS_HUNT      = 2'd0;
  localparam logic [1:0] POS_CHECKSUM  = 2'(FRAME_LEN - 1);

  // configuration
  localparam int          HEIGHT_W     = 16;
  localparam logic [15:0] HEIGHT_RESET = 16'd850;

  // level arithmetic: distance * 100 fits in 23 bits
  localparam int DIST_W        = 16;
  localparam int PERCENT_SCALE = 100;
  localparam int DIV_BITS      = 23;
  localparam int DIV_CNT_W     = $clog2(DIV_BITS);
  localparam int COUNT_W       = 32;

  // controller states
  typedef enum logic [1:0] {
    ST_RECV,
    ST_DIV,
    ST_LOAD
  } lsfp_state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;    // store a payload byte
    logic byte_sel;   // 0 high distance byte, 1 low distance byte
    logic check;      // checksum byte: latch verdict, start divider
    logic div_step;   // one restoring division step
    logic load_out;   // write result into output register
  } lsfp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_sync;    // incoming byte is the sync byte
    logic sum_ok;     // incoming byte matches frame checksum
    logic height_zero;
    logic div_last;   // current step is the final division step
    logic out_free;   // output register can take a result this cycle
  } lsfp_stat_t;

endpackage

// ----- sv/lsfp_ctrl.sv -----
// ----------------------------------------------------------------------------
// lsfp_ctrl
// Frame controller: tracks the byte position, hunts for sync, sequences the
// level division and hands the finished result to the output register.
// ----------------------------------------------------------------------------
module lsfp_ctrl
  import lsfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_xfer,
  input  lsfp_stat_t stat,
  output logic       in_ready,
  output lsfp_cmd_t  cmd
);

  lsfp_state_t state, state_next;
  logic [1:0]  byte_pos, byte_pos_next;

  // state and position registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_RECV;
      byte_pos <= POS_HUNT;
    end else begin
      state    <= state_next;
      byte_pos <= byte_pos_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_RECV: begin
        if (in_xfer && byte_pos == POS_CHECKSUM) begin
          if (!stat.sum_ok || stat.height_zero) state_next = ST_LOAD;
          else                                   state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (stat.div_last) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (stat.out_free) state_next = ST_RECV;
      end
      default: state_next = ST_RECV;
    endcase
  end

  // byte position within the frame
  always_comb begin
    byte_pos_next = byte_pos;
    if (in_xfer) begin
      priority if (byte_pos == POS_HUNT) begin
        if (stat.is_sync) byte_pos_next = 2'd1;
      end else if (byte_pos == POS_CHECKSUM) begin
        byte_pos_next = POS_HUNT;
      end else begin
        byte_pos_next = byte_pos + 2'd1;
      end
    end
  end

  // outputs
  always_comb begin
    cmd          = '0;
    in_ready     = 1'b0;
    cmd.byte_sel = byte_pos[1];
    unique case (state)
      ST_RECV: begin
        in_ready    = 1'b1;
        cmd.capture = in_xfer && byte_pos != POS_HUNT && byte_pos != POS_CHECKSUM;
        cmd.check   = in_xfer && byte_pos == POS_CHECKSUM;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_LOAD: begin
        cmd.load_out = stat.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // a frame only leaves hunting on the sync byte
  a_sync_entry: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && byte_pos == POS_HUNT && !stat.is_sync) |=> byte_pos == POS_HUNT)
    else $error("left hunt without sync byte");

  // division always runs its full length before the result is loaded
  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD && $past(state) == ST_DIV) |-> $past(stat.div_last))
    else $error("division cut short");

  // no byte taken while a frame result is pending
  a_no_take: assert property (@(posedge clk) disable iff (rst)
    (state != ST_RECV) |-> !in_xfer)
    else $error("byte taken outside receive");

endmodule

// ----- sv/lsfp_datapath.sv -----
// ----------------------------------------------------------------------------
// lsfp_datapath
// Frame datapath: payload byte store, checksum compare, tank height
// register, bit-serial restoring divider for the level, frame counters and
// the output register.
// ----------------------------------------------------------------------------
module lsfp_datapath
  import lsfp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          rx_byte,
  input  logic                cfg_wr_en,
  input  logic [HEIGHT_W-1:0] cfg_wr_data,
  input  lsfp_cmd_t           cmd,
  output lsfp_stat_t          stat,
  input  logic                out_ready,
  output logic                out_valid,
  output logic                out_frame_error,
  output logic [DIST_W-1:0]   out_echo_range,
  output logic [15:0]         out_fill_level,
  output logic [COUNT_W-1:0]  out_valid_count,
  output logic [COUNT_W-1:0]  out_bad_count
);

  logic [HEIGHT_W-1:0]  tank_height;
  logic [7:0]           dist_hi, dist_lo;
  logic [7:0]           sum;
  logic [DIST_W-1:0]    distance;
  logic [DIV_BITS-1:0]  product;

  logic                 frame_error;
  logic                 height_zero;
  logic [HEIGHT_W-1:0]  divisor;
  logic [HEIGHT_W-1:0]  rem;
  logic [DIV_BITS-1:0]  quo;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [HEIGHT_W:0]    rem_shift;
  logic                 rem_ge;
  logic [HEIGHT_W:0]    rem_diff;
  logic [15:0]          level;

  logic [COUNT_W-1:0]   good_frames, failed_frames;

  // tank height register
  always_ff @(posedge clk) begin
    if (rst) begin
      tank_height <= HEIGHT_RESET;
    end else if (cfg_wr_en) begin
      tank_height <= cfg_wr_data;
    end
  end

  // payload byte store; the first frame byte is always the sync byte
  always_ff @(posedge clk) begin
    if (rst) begin
      dist_hi <= '0;
      dist_lo <= '0;
    end else if (cmd.capture) begin
      if (cmd.byte_sel) dist_lo <= rx_byte;
      else              dist_hi <= rx_byte;
    end
  end

  // checksum and scaled distance
  assign sum      = SYNC_BYTE + dist_hi + dist_lo;
  assign distance = {dist_hi, dist_lo};
  assign product  = DIV_BITS'(distance) * DIV_BITS'(PERCENT_SCALE);

  // restoring division step
  assign rem_shift = {rem, quo[DIV_BITS-1]};
  assign rem_ge    = rem_shift >= {1'b0, divisor};
  assign rem_diff  = rem_shift - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      frame_error <= (sum != rx_byte);
      height_zero <= (tank_height == '0);
      divisor     <= tank_height;
      rem         <= '0;
      quo         <= product;
      div_cnt     <= '0;
    end else if (cmd.div_step) begin
      rem     <= rem_ge ? rem_diff[HEIGHT_W-1:0] : rem_shift[HEIGHT_W-1:0];
      quo     <= {quo[DIV_BITS-2:0], rem_ge};
      div_cnt <= div_cnt + 1'b1;
    end
  end

  // saturated level
  always_comb begin
    priority if (frame_error || height_zero) level = '0;
    else if (quo[DIV_BITS-1:16] != '0)       level = '1;
    else                                     level = quo[15:0];
  end

  // frame counters
  always_ff @(posedge clk) begin
    if (rst) begin
      good_frames   <= '0;
      failed_frames <= '0;
    end else if (cmd.load_out) begin
      if (frame_error) failed_frames <= failed_frames + 1'b1;
      else             good_frames   <= good_frames + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_frame_error <= frame_error;
      out_echo_range  <= frame_error ? '0 : distance;
      out_fill_level  <= level;
      out_valid_count <= frame_error ? good_frames : good_frames + 1'b1;
      out_bad_count   <= frame_error ? failed_frames + 1'b1 : failed_frames;
    end
  end

  // status back to controller
  always_comb begin
    stat.is_sync     = (rx_byte == SYNC_BYTE);
    stat.sum_ok      = (sum == rx_byte);
    stat.height_zero = (tank_height == '0);
    stat.div_last    = (div_cnt == DIV_CNT_W'(DIV_BITS - 1));
    stat.out_free    = !out_valid || out_ready;
  end

  // a result is never loaded over one that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("output register overwritten");

  // a bad frame reports zero distance and level
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_frame_error) |-> (out_echo_range == '0 && out_fill_level == '0))
    else $error("bad frame with nonzero payload");

  // exactly one counter moves per delivered frame
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.load_out) |->
      ((good_frames - $past(good_frames)) + (failed_frames - $past(failed_frames)) == 1))
    else $error("frame counters out of step");

  // zero distance never gives a nonzero level
  a_level_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_echo_range == '0) |-> out_fill_level == '0)
    else $error("level without distance");

endmodule

// ----- sv/level_sensor_frame_parser.sv -----
// Level sensor frame parser. Takes received sensor bytes on the slave stream,
// hunts for the 0xFF sync byte and collects a four-byte frame (sync, distance
// high, distance low, checksum). Each completed frame gives one transfer on the
// master stream; other bytes give none. The checksum byte of a frame with
// a good checksum and nonzero tank height starts a bit-serial restoring
// divider that gives one quotient bit per cycle; a bad frame or zero height
// skips it. No byte is taken from the checksum byte until the result is
// loaded into the output register; the load waits while that register still
// holds an untaken result. The output register lets the next frame's bytes come in while the
// previous result waits. Write tank_height only while no frame is in flight.
// ----------------------------------------------------------------------------
// level_sensor_frame_parser
// Top level: stream ports, configuration port, controller and datapath.
// ----------------------------------------------------------------------------
module level_sensor_frame_parser
  import lsfp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // configuration: tank height in mm
  input  logic                cfg_wr_en,
  input  logic [HEIGHT_W-1:0] cfg_wr_data,
  // received byte stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] rx_byte
  // frame result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [95:0]         m_axis_tdata,   // [15:0] echo_range, [31:16] fill_level,
                                              // [63:32] valid_count, [95:64] bad_count
  output logic                m_axis_tuser    // [0] frame_error
);

  lsfp_cmd_t  cmd;
  lsfp_stat_t stat;
  logic       in_xfer;

  logic [DIST_W-1:0]  echo_range;
  logic [15:0]        fill_level;
  logic [COUNT_W-1:0] valid_count;
  logic [COUNT_W-1:0] bad_count;

  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // frame controller
  lsfp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_xfer  (in_xfer),
    .stat     (stat),
    .in_ready (s_axis_tready),
    .cmd      (cmd)
  );

  // frame datapath
  lsfp_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .rx_byte         (s_axis_tdata),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .cmd             (cmd),
    .stat            (stat),
    .out_ready       (m_axis_tready),
    .out_valid       (m_axis_tvalid),
    .out_frame_error (m_axis_tuser),
    .out_echo_range  (echo_range),
    .out_fill_level  (fill_level),
    .out_valid_count (valid_count),
    .out_bad_count   (bad_count)
  );

  // result packing
  assign m_axis_tdata = {bad_count, valid_count, fill_level, echo_range};

endmodule

// ----- sim/frame_result_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_result_checker
// Watches the byte stream, the configuration port and the result stream of
// the level sensor frame parser. It tracks the frame parser state itself,
// queues the result each completed frame should give and compares every
// result transfer with the oldest queued one, field by field.
// ----------------------------------------------------------------------------
module frame_result_checker
  import lsfp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [HEIGHT_W-1:0] cfg_wr_data,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [95:0]         m_axis_tdata,
  input  logic                m_axis_tuser,
  output int                  mismatches,
  output int                  pending,
  output logic [1:0]          frame_pos,
  output int                  good_frames_seen,
  output int                  bad_frames_seen
);

  typedef struct packed {
    logic                frame_error;
    logic [DIST_W-1:0]   echo_range;
    logic [15:0]         fill_level;
    logic [COUNT_W-1:0]  valid_count;
    logic [COUNT_W-1:0]  bad_count;
  } frame_result_t;

  logic [HEIGHT_W-1:0] tank_height;
  logic [7:0]          frame_buf [3];
  logic [COUNT_W-1:0]  good_total;
  logic [COUNT_W-1:0]  bad_total;
  frame_result_t       expected_results [$];

  // distance * 100 / height, zero for zero height, clipped to 16 bits
  function automatic logic [15:0] scaled_level(input logic [DIST_W-1:0] distance,
                                               input logic [HEIGHT_W-1:0] height);
    logic [31:0] quot;
    if (height == '0) return '0;
    quot = (32'(distance) * 32'(PERCENT_SCALE)) / 32'(height);
    return (quot > 32'h0000_FFFF) ? 16'hFFFF : quot[15:0];
  endfunction

  // advance the frame parser by one byte, queue a result when a frame closes
  task automatic parse_rx_byte(input logic [7:0] rx_byte);
    logic [7:0]    sum;
    frame_result_t res;
    if (frame_pos == POS_HUNT) begin
      if (rx_byte == SYNC_BYTE) begin
        frame_buf[0] = rx_byte;
        frame_pos    = frame_pos + 2'd1;
      end
    end else if (frame_pos != POS_CHECKSUM) begin
      // sync byte inside a frame is plain data here
      frame_buf[frame_pos] = rx_byte;
      frame_pos            = frame_pos + 2'd1;
    end else begin
      frame_pos = POS_HUNT;
      sum = frame_buf[0] + frame_buf[1] + frame_buf[2];
      if (sum != rx_byte) begin
        bad_total       = bad_total + 1'b1;
        res.frame_error = 1'b1;
        res.echo_range  = '0;
        res.fill_level  = '0;
      end else begin
        good_total      = good_total + 1'b1;
        res.frame_error = 1'b0;
        res.echo_range  = {frame_buf[1], frame_buf[2]};
        res.fill_level  = scaled_level({frame_buf[1], frame_buf[2]}, tank_height);
      end
      res.valid_count = good_total;
      res.bad_count   = bad_total;
      expected_results.push_back(res);
    end
  endtask

  // compare result transfers, then track byte transfers and config writes
  always @(posedge clk) begin
    frame_result_t got;
    frame_result_t want;
    if (rst) begin
      tank_height      = HEIGHT_RESET;
      frame_pos        = POS_HUNT;
      frame_buf[0]     = '0;
      frame_buf[1]     = '0;
      frame_buf[2]     = '0;
      good_total       = '0;
      bad_total        = '0;
      mismatches       = 0;
      good_frames_seen = 0;
      bad_frames_seen  = 0;
      expected_results.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.frame_error = m_axis_tuser;
        got.echo_range  = m_axis_tdata[15:0];
        got.fill_level  = m_axis_tdata[31:16];
        got.valid_count = m_axis_tdata[63:32];
        got.bad_count   = m_axis_tdata[95:64];
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with none expected: err=%0d dist=%0d level=%0d good=%0d bad=%0d",
                     $realtime, got.frame_error, got.echo_range, got.fill_level,
                     got.valid_count, got.bad_count);
        end else begin
          want = expected_results.pop_front();
          if (want.frame_error) bad_frames_seen++;
          else good_frames_seen++;
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: frame result mismatch", $realtime);
              $display("  expected err=%0d dist=%0d level=%0d good=%0d bad=%0d",
                       want.frame_error, want.echo_range, want.fill_level,
                       want.valid_count, want.bad_count);
              $display("  actual   err=%0d dist=%0d level=%0d good=%0d bad=%0d",
                       got.frame_error, got.echo_range, got.fill_level,
                       got.valid_count, got.bad_count);
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) parse_rx_byte(s_axis_tdata);
      if (cfg_wr_en) tank_height = cfg_wr_data;
    end
    pending = expected_results.size();
  end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the level sensor frame parser. A short directed byte sequence
// is followed by phases of random frames (good, corrupted, truncated, noise)
// under several tank heights and receiver patterns, with bursty input and one
// long output hold-off. The checker module predicts and compares results.
// ----------------------------------------------------------------------------
module tb_top;
  import lsfp_pkg::*;

  localparam int HOLDOFF_CYCLES = 400;
  localparam int DRAIN_CYCLES   = 40;
  localparam int PHASE_STEPS    = 42;

  typedef enum {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PATTERN,
    RX_SPARSE
  } rx_mode_t;

  logic                clk           = 1'b0;
  logic                rst           = 1'b1;
  logic                cfg_wr_en     = 1'b0;
  logic [HEIGHT_W-1:0] cfg_wr_data   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [95:0]         m_axis_tdata;
  logic                m_axis_tuser;

  int         mismatches;
  int         pending;
  logic [1:0] frame_pos;
  int         good_frames_seen;
  int         bad_frames_seen;

  rx_mode_t rx_mode      = RX_ALWAYS;
  bit       holdoff_req  = 1'b0;
  int       holdoff_left = 0;
  int       rx_tick      = 0;
  int       burst_left   = 0;
  int       gap_max      = 6;
  int       height_writes = 0;

  level_sensor_frame_parser dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  frame_result_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tuser     (m_axis_tuser),
    .mismatches       (mismatches),
    .pending          (pending),
    .frame_pos        (frame_pos),
    .good_frames_seen (good_frames_seen),
    .bad_frames_seen  (bad_frames_seen)
  );

  // clock
  always #5 clk = ~clk;

  // run limit
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // result receiver: long hold-off on request, otherwise the current pattern
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      holdoff_left = 0;
    end else if (holdoff_req) begin
      holdoff_req = 1'b0;
      holdoff_left = HOLDOFF_CYCLES - 1;
      m_axis_tready <= 1'b0;
    end else if (holdoff_left > 0) begin
      holdoff_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS:  m_axis_tready <= 1'b1;
        RX_RANDOM:  m_axis_tready <= 1'($urandom_range(0, 1));
        RX_PATTERN: m_axis_tready <= (rx_tick % 7) < 3;
        default:    m_axis_tready <= ($urandom_range(0, 4) == 0);
      endcase
    end
    rx_tick++;
  end

  // one byte transfer, bursts separated by random gaps
  task automatic push_byte(input logic [7:0] rx_byte);
    int gap;
    bit took;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= rx_byte;
    do begin
      @(negedge clk);
      took = s_axis_tready;
      @(posedge clk);
    end while (!took);
    burst_left--;
  endtask

  // sync, distance high, distance low, checksum (optionally corrupted)
  task automatic push_frame(input logic [15:0] distance, input bit corrupt);
    logic [7:0] csum;
    csum = SYNC_BYTE + distance[15:8] + distance[7:0];
    if (corrupt) csum = csum ^ 8'($urandom_range(1, 255));
    push_byte(SYNC_BYTE);
    push_byte(distance[15:8]);
    push_byte(distance[7:0]);
    push_byte(csum);
  endtask

  // close any partial frame, then wait for all results and the divider
  task automatic settle_idle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (frame_pos != POS_HUNT) begin
      @(posedge clk);
      push_byte(8'h00);
      s_axis_tvalid <= 1'b0;
      burst_left = 0;
      @(negedge clk);
    end
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_height(input logic [HEIGHT_W-1:0] height);
    settle_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= height;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    height_writes++;
  endtask

  // mostly spread distances, with extremes and short ranges mixed in
  function automatic logic [15:0] pick_distance();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom_range(0, 1200));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // stimulus
  initial begin
    int             p;
    int             k;
    int             n;
    int             pick;
    logic [15:0]    height;
    logic [15:0]    phase_heights [9];

    phase_heights = '{16'd0, 16'hFFFF, 16'd1, 16'd99, 16'd100,
                      16'($urandom_range(0, 65535)), 16'($urandom_range(1, 2000)),
                      HEIGHT_RESET, 16'($urandom_range(0, 65535))};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: noise while hunting, zero and full distance, bad checksum,
    // sync bytes as data, level of exactly 100 at the reset height
    gap_max = 0;
    push_byte(8'h00);
    push_byte(8'h7E);
    push_byte(SYNC_BYTE); push_byte(8'h00); push_byte(8'h00); push_byte(8'hFF);
    push_byte(SYNC_BYTE); push_byte(8'hFF); push_byte(8'hFF); push_byte(8'hFD);
    push_byte(SYNC_BYTE); push_byte(8'h12); push_byte(8'h34); push_byte(8'h00);
    push_byte(SYNC_BYTE); push_byte(8'h03); push_byte(8'h52); push_byte(8'h54);
    push_byte(SYNC_BYTE); push_byte(8'h00); push_byte(8'h01); push_byte(8'h00);

    // random phases, one tank height and receiver pattern each
    for (p = 0; p < 9; p++) begin
      height = phase_heights[p];
      write_height(height);
      rx_mode = rx_mode_t'(p % 4);
      gap_max = (p % 3 == 0) ? 0 : 6;
      if (p == 2) begin
        rx_mode = RX_ALWAYS;
        holdoff_req = 1'b1;
      end
      for (k = 0; k < PHASE_STEPS; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          push_frame(pick_distance(), 1'b0);
        end else if (pick < 85) begin
          push_frame(pick_distance(), 1'b1);
        end else if (pick < 95) begin
          n = $urandom_range(1, 3);
          repeat (n) push_byte(8'($urandom_range(0, 255)));
        end else begin
          // truncated frame: following bytes get absorbed as its payload
          push_byte(SYNC_BYTE);
          n = $urandom_range(1, 2);
          repeat (n) push_byte(8'($urandom_range(0, 255)));
        end
      end
    end

    rx_mode = RX_RANDOM;
    settle_idle();

    $display("covered %0d good and %0d bad frames over %0d tank height settings,",
             good_frames_seen, bad_frames_seen, height_writes + 1);
    $display("with bursty input, four receiver patterns and a %0d-cycle output hold-off",
             HOLDOFF_CYCLES);
    if (mismatches == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- level_sensor_frame_parser.f -----
sv/lsfp_pkg.sv
sv/lsfp_ctrl.sv
sv/lsfp_datapath.sv
sv/level_sensor_frame_parser.sv
sim/frame_result_checker.sv
sim/tb_top.sv
